// ===== hdl/pedc_pkg.sv =====
// Shared types, constants and codes for the periodic emitter with distance cull.
package pedc_pkg;

    localparam int ID_LIMIT_DEF    = 80;
    localparam int COORD_WIDTH_DEF = 24;

    localparam int TIME_W      = 32;
    localparam int INTERVAL_W  = 31;
    localparam int RADIUS_W    = 23;
    localparam int ID_W        = 7;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // Coordinate differences are formed at this width and saturated to MAG_W bits.
    localparam int DIFF_CALC_W = 34;
    localparam int MAG_W       = 24;
    localparam logic [MAG_W-1:0] DIFF_SAT = MAG_W'(24'h800000);
    localparam int SQ_W        = 2 * MAG_W;
    localparam int SQ_CNT_W    = 2;

    localparam int FIFO_DEPTH  = 2;

    // Remainder unit: DIV_BITS quotient bits per cycle; DIV_STEPS is the number of steps.
    localparam int DIV_BITS    = 4;
    localparam int DIV_STEPS   = 8;
    localparam int DIV_SHIFT_W = DIV_BITS * DIV_STEPS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_EMIT_INTERVAL = 3'd0,
        REG_CULL_RADIUS   = 3'd1,
        REG_EFFECT_ID     = 3'd2,
        REG_DIR_X         = 3'd3,
        REG_DIR_Y         = 3'd4,
        REG_DIR_Z         = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OUT_NOT_DUE       = 3'd0,
        OUT_CULLED        = 3'd1,
        OUT_PLAY_ORIGIN   = 3'd2,
        OUT_PLAY_ORIENTED = 3'd3,
        OUT_BAD_ID        = 3'd4
    } outcome_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CADENCE,
        B_DIVIDE,
        B_SQUARE,
        B_COMPARE,
        B_EMIT
    } back_state_t;

    // Configuration as the back end sees it.
    typedef struct packed {
        logic [INTERVAL_W-1:0] interval;   // zero already mapped to one
        logic [RADIUS_W-1:0]   radius;
        logic [ID_W-1:0]       effect_id;
        logic                  oriented;   // some direction component is nonzero
    } cfg_t;

    // One queued word: tick time and saturated separation magnitudes.
    typedef struct packed {
        logic [TIME_W-1:0] now_time;
        logic [MAG_W-1:0]  dx;
        logic [MAG_W-1:0]  dy;
        logic [MAG_W-1:0]  dz;
    } item_t;

endpackage

// ===== hdl/pedc_front.sv =====
// Front end: accepts tick words and reduces positions to saturated separations.
module pedc_front #(
    parameter int COORD_WIDTH = pedc_pkg::COORD_WIDTH_DEF
) (
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic signed [31:0]            now_time,
    input  logic signed [COORD_WIDTH-1:0] emit_x,
    input  logic signed [COORD_WIDTH-1:0] emit_y,
    input  logic signed [COORD_WIDTH-1:0] emit_z,
    input  logic signed [COORD_WIDTH-1:0] view_x,
    input  logic signed [COORD_WIDTH-1:0] view_y,
    input  logic signed [COORD_WIDTH-1:0] view_z,
    input  logic                          fifo_full,
    output logic                          fifo_push,
    output pedc_pkg::item_t               fifo_item
);
    import pedc_pkg::*;

    function automatic logic [MAG_W-1:0] sat_mag(
        input logic signed [DIFF_CALC_W-1:0] a,
        input logic signed [DIFF_CALC_W-1:0] b
    );
        logic signed [DIFF_CALC_W-1:0] d;
        logic [DIFF_CALC_W-1:0]        m;
        d = a - b;
        m = d[DIFF_CALC_W-1] ? DIFF_CALC_W'(-d) : DIFF_CALC_W'(d);
        if (m > DIFF_CALC_W'(DIFF_SAT)) begin
            return DIFF_SAT;
        end
        return m[MAG_W-1:0];
    endfunction

    logic signed [DIFF_CALC_W-1:0] ex;
    logic signed [DIFF_CALC_W-1:0] ey;
    logic signed [DIFF_CALC_W-1:0] ez;
    logic signed [DIFF_CALC_W-1:0] vx;
    logic signed [DIFF_CALC_W-1:0] vy;
    logic signed [DIFF_CALC_W-1:0] vz;

    assign ex = DIFF_CALC_W'(emit_x);
    assign ey = DIFF_CALC_W'(emit_y);
    assign ez = DIFF_CALC_W'(emit_z);
    assign vx = DIFF_CALC_W'(view_x);
    assign vy = DIFF_CALC_W'(view_y);
    assign vz = DIFF_CALC_W'(view_z);

    assign item_stall = fifo_full;
    assign fifo_push  = item_valid && !fifo_full;

    always_comb
    begin
        fifo_item.now_time = now_time;
        fifo_item.dx       = sat_mag(ex, vx);
        fifo_item.dy       = sat_mag(ey, vy);
        fifo_item.dz       = sat_mag(ez, vz);
    end

endmodule

// ===== hdl/pedc_fifo.sv =====
// Short word queue between the front end and the back end.
module pedc_fifo #(
    parameter int DEPTH = pedc_pkg::FIFO_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pedc_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output pedc_pkg::item_t pop_item
);
    import pedc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/pedc_rem.sv =====
// Iterative remainder unit, several restoring steps per cycle.
module pedc_rem (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pedc_pkg::INTERVAL_W-1:0] dividend,
    input  logic [pedc_pkg::INTERVAL_W-1:0] divisor,
    output logic                            done,
    output logic [pedc_pkg::INTERVAL_W-1:0] rem
);
    import pedc_pkg::*;

    logic                   busy_reg;
    logic                   busy_next;
    logic                   done_reg;
    logic                   done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;
    logic [DIV_SHIFT_W-1:0] shift_reg;
    logic [DIV_SHIFT_W-1:0] shift_next;
    logic [INTERVAL_W-1:0]  rem_reg;
    logic [INTERVAL_W-1:0]  rem_next;

    assign done = done_reg;
    assign rem  = rem_reg;

    // Bring down DIV_BITS dividend bits; the partial remainder stays below the divisor.
    always_comb
    begin
        logic [INTERVAL_W:0]    t;
        logic [INTERVAL_W-1:0]  r;
        logic [DIV_SHIFT_W-1:0] s;
        r = rem_reg;
        s = shift_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {r, s[DIV_SHIFT_W-1]};
            s = {s[DIV_SHIFT_W-2:0], 1'b0};
            if (t >= {1'b0, divisor}) begin
                t = t - {1'b0, divisor};
            end
            r = t[INTERVAL_W-1:0];
        end
        rem_next   = r;
        shift_next = s;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            shift_reg <= DIV_SHIFT_W'(dividend);
            rem_reg   <= '0;
        end else if (busy_reg) begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

// ===== hdl/pedc_back.sv =====
// Back end: cadence tracking, distance cull and result register.
module pedc_back #(
    parameter int ID_LIMIT = pedc_pkg::ID_LIMIT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fifo_empty,
    input  pedc_pkg::item_t           fifo_item,
    output logic                      fifo_pop,
    input  pedc_pkg::cfg_t            cfg,
    output logic                      result_valid,
    input  logic                      result_stall,
    output pedc_pkg::outcome_t        outcome,
    output logic [pedc_pkg::ID_W-1:0] play_id
);
    import pedc_pkg::*;

    back_state_t           state_reg;
    back_state_t           state_next;
    item_t                 item_reg;
    logic [TIME_W-1:0]     next_emit_reg;
    logic [TIME_W-1:0]     next_emit_next;
    logic                  next_emit_we;
    outcome_t              res_outcome_reg;
    outcome_t              res_outcome_next;
    logic [ID_W-1:0]       res_id_reg;
    logic [ID_W-1:0]       res_id_next;
    logic                  res_we;
    logic [SQ_CNT_W-1:0]   sq_cnt_reg;
    logic [SQ_CNT_W-1:0]   sq_cnt_next;
    logic                  sq_run;
    logic [SQ_W-1:0]       prod_reg;
    logic [SQ_W-1:0]       prod_next;
    logic [SQ_W-1:0]       acc_reg;
    logic [SQ_W-1:0]       acc_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    outcome_t              out_outcome_reg;
    logic [ID_W-1:0]       out_id_reg;
    logic                  out_load;

    logic                  div_start;
    logic                  div_done;
    logic [INTERVAL_W-1:0] div_rem;
    logic [INTERVAL_W-1:0] div_dividend;

    logic [TIME_W-1:0]     elapsed;
    logic [TIME_W-1:0]     elapsed_m1;
    logic [TIME_W-1:0]     ivl_ext;
    logic [TIME_W-1:0]     next_from_div;
    logic                  at_or_before;
    logic                  not_due;
    logic                  one_step;
    logic                  cull_on;
    logic                  id_bad;
    outcome_t              play_res;
    back_state_t           fire_state;
    logic [MAG_W-1:0]      sq_op;
    logic                  in_range;
    logic                  out_free;

    assign elapsed       = item_reg.now_time - next_emit_reg;
    assign elapsed_m1    = elapsed - TIME_W'(1);
    assign div_dividend  = elapsed_m1[INTERVAL_W-1:0];
    assign ivl_ext       = {1'b0, cfg.interval};
    assign at_or_before  = $signed(item_reg.now_time) <= $signed(next_emit_reg);
    assign not_due       = $signed(elapsed) < $signed(ivl_ext);
    assign one_step      = elapsed == ivl_ext;
    // Catch-up lands on now - 1 - ((elapsed - 1) mod interval).
    assign next_from_div = item_reg.now_time + ~{1'b0, div_rem};

    assign cull_on    = cfg.radius != '0;
    assign id_bad     = (cfg.effect_id == '0) ||
                        ({1'b0, cfg.effect_id} >= (ID_W + 1)'(ID_LIMIT));
    assign play_res   = id_bad ? OUT_BAD_ID :
                        (cfg.oriented ? OUT_PLAY_ORIENTED : OUT_PLAY_ORIGIN);
    assign fire_state = cull_on ? B_SQUARE : B_EMIT;
    assign in_range   = acc_reg < prod_reg;
    assign out_free   = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign outcome      = out_outcome_reg;
    assign play_id      = out_id_reg;

    pedc_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cfg.interval),
        .done     (div_done),
        .rem      (div_rem)
    );

    // One shared squarer: dx, dy, dz, then the radius.
    always_comb
    begin
        unique case (sq_cnt_reg)
            2'd0:    sq_op = item_reg.dx;
            2'd1:    sq_op = item_reg.dy;
            2'd2:    sq_op = item_reg.dz;
            default: sq_op = MAG_W'(cfg.radius);
        endcase
        prod_next = sq_op * sq_op;
        acc_next  = (sq_cnt_reg == 2'd1) ? prod_reg : acc_reg + prod_reg;
        sq_cnt_next = sq_cnt_reg + 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!fifo_empty) begin
                    state_next = B_CADENCE;
                end
            end
            B_CADENCE:
            begin
                priority if (at_or_before || one_step) begin
                    state_next = fire_state;
                end else if (not_due) begin
                    state_next = B_EMIT;
                end else begin
                    state_next = B_DIVIDE;
                end
            end
            B_DIVIDE:
            begin
                if (div_done) begin
                    state_next = fire_state;
                end
            end
            B_SQUARE:
            begin
                if (sq_cnt_reg == SQ_CNT_W'(3)) begin
                    state_next = B_COMPARE;
                end
            end
            B_COMPARE:
            begin
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fifo_pop         = 1'b0;
        div_start        = 1'b0;
        next_emit_we     = 1'b0;
        next_emit_next   = item_reg.now_time;
        res_we           = 1'b0;
        res_outcome_next = play_res;
        res_id_next      = cfg.effect_id;
        sq_run           = 1'b0;
        out_load         = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                fifo_pop = !fifo_empty;
            end
            B_CADENCE:
            begin
                priority if (at_or_before || one_step) begin
                    next_emit_we = 1'b1;
                    res_we       = 1'b1;
                end else if (not_due) begin
                    res_we           = 1'b1;
                    res_outcome_next = OUT_NOT_DUE;
                    res_id_next      = '0;
                end else begin
                    div_start = 1'b1;
                end
            end
            B_DIVIDE:
            begin
                if (div_done) begin
                    next_emit_we   = 1'b1;
                    next_emit_next = next_from_div;
                    res_we         = 1'b1;
                end
            end
            B_SQUARE:
            begin
                sq_run = 1'b1;
            end
            B_COMPARE:
            begin
                if (!in_range) begin
                    res_we           = 1'b1;
                    res_outcome_next = OUT_CULLED;
                    res_id_next      = '0;
                end
            end
            B_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                fifo_pop = 1'b0;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= B_IDLE;
            next_emit_reg <= '0;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (next_emit_we) begin
                next_emit_reg <= next_emit_next;
            end
            if (sq_run) begin
                sq_cnt_reg <= sq_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_pop) begin
            item_reg <= fifo_item;
        end
        if (res_we) begin
            res_outcome_reg <= res_outcome_next;
            res_id_reg      <= res_id_next;
        end
        if (sq_run) begin
            prod_reg <= prod_next;
            if (sq_cnt_reg != '0) begin
                acc_reg <= acc_next;
            end
        end
        if (out_load) begin
            out_outcome_reg <= res_outcome_reg;
            out_id_reg      <= res_id_reg;
        end
    end

endmodule

// ===== hdl/periodic_emitter_distance_cull.sv =====
// The back-end sequencer handles one word at a time, from acceptance to result; its
// longest path is catch-up in the remainder unit (4 bits per cycle) followed by the
// cull on the shared squarer, and a tick that is not due skips both. A two-word queue
// lets the front keep accepting.
// Reset clears the next-emit time and the queue and returns the registers to their
// reset values (interval 1, all others 0); no clearing pass follows.
module periodic_emitter_distance_cull #(
    parameter int ID_LIMIT    = pedc_pkg::ID_LIMIT_DEF,
    parameter int COORD_WIDTH = pedc_pkg::COORD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic signed [31:0]                 now_time,
    input  logic signed [COORD_WIDTH-1:0]      emit_x,
    input  logic signed [COORD_WIDTH-1:0]      emit_y,
    input  logic signed [COORD_WIDTH-1:0]      emit_z,
    input  logic signed [COORD_WIDTH-1:0]      view_x,
    input  logic signed [COORD_WIDTH-1:0]      view_y,
    input  logic signed [COORD_WIDTH-1:0]      view_z,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [2:0]                         outcome,
    output logic [pedc_pkg::ID_W-1:0]          play_id,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pedc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pedc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pedc_pkg::*;

    logic [INTERVAL_W-1:0]  emit_interval_reg;
    logic [RADIUS_W-1:0]    cull_radius_reg;
    logic [ID_W-1:0]        effect_id_reg;
    logic [COORD_WIDTH-1:0] dir_x_reg;
    logic [COORD_WIDTH-1:0] dir_y_reg;
    logic [COORD_WIDTH-1:0] dir_z_reg;
    logic                   cfg_we;

    cfg_t     cfg;
    item_t    push_item;
    item_t    pop_item;
    logic     fifo_push;
    logic     fifo_pop;
    logic     fifo_full;
    logic     fifo_empty;
    outcome_t back_outcome;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            emit_interval_reg <= INTERVAL_W'(1);
            cull_radius_reg   <= '0;
            effect_id_reg     <= '0;
            dir_x_reg         <= '0;
            dir_y_reg         <= '0;
            dir_z_reg         <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_EMIT_INTERVAL: emit_interval_reg <= cfg_data[INTERVAL_W-1:0];
                REG_CULL_RADIUS:   cull_radius_reg   <= cfg_data[RADIUS_W-1:0];
                REG_EFFECT_ID:     effect_id_reg     <= cfg_data[ID_W-1:0];
                REG_DIR_X:         dir_x_reg         <= cfg_data[COORD_WIDTH-1:0];
                REG_DIR_Y:         dir_y_reg         <= cfg_data[COORD_WIDTH-1:0];
                REG_DIR_Z:         dir_z_reg         <= cfg_data[COORD_WIDTH-1:0];
                default:           effect_id_reg     <= effect_id_reg;
            endcase
        end
    end

    // A zero interval behaves as one.
    always_comb
    begin
        cfg.interval  = (emit_interval_reg == '0) ? INTERVAL_W'(1) : emit_interval_reg;
        cfg.radius    = cull_radius_reg;
        cfg.effect_id = effect_id_reg;
        cfg.oriented  = (dir_x_reg != '0) || (dir_y_reg != '0) || (dir_z_reg != '0);
    end

    pedc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .now_time   (now_time),
        .emit_x     (emit_x),
        .emit_y     (emit_y),
        .emit_z     (emit_z),
        .view_x     (view_x),
        .view_y     (view_y),
        .view_z     (view_z),
        .fifo_full  (fifo_full),
        .fifo_push  (fifo_push),
        .fifo_item  (push_item)
    );

    pedc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .empty     (fifo_empty),
        .pop_item  (pop_item)
    );

    pedc_back #(
        .ID_LIMIT (ID_LIMIT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fifo_empty   (fifo_empty),
        .fifo_item    (pop_item),
        .fifo_pop     (fifo_pop),
        .cfg          (cfg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .outcome      (back_outcome),
        .play_id      (play_id)
    );

    assign outcome = back_outcome;

endmodule
